// ===== sv/bsc_pkg.sv =====
// Shared types, constants and helpers for the byte stream cipher with tag.
// No dependencies.
`default_nettype none
package bsc_pkg;

    localparam logic [31:0] MUL_STEP   = 32'hBF58476D;
    localparam logic [31:0] MUL_GOLD   = 32'h9E3779B9;
    localparam logic [31:0] TAG_INIT_A = 32'h6A09E667;
    localparam logic [31:0] TAG_INIT_B = 32'hBB67AE85;
    localparam logic [31:0] MUL_FINAL  = 32'h94D049BB;
    localparam logic [31:0] MUL_COUNT  = 32'h6C62272E;

    localparam int NUM_WORDS = 8;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_DIR  = 3'd4;

    typedef logic [NUM_WORDS-1:0][31:0] t_words;

    typedef struct packed {
        logic        en;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_M1   = 11'b000_0000_0010,
        S_UPD  = 11'b000_0000_0100,
        S_M2   = 11'b000_0000_1000,
        S_A    = 11'b000_0001_0000,
        S_M3   = 11'b000_0010_0000,
        S_B    = 11'b000_0100_0000,
        S_H    = 11'b000_1000_0000,
        S_F    = 11'b001_0000_0000,
        S_T    = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage
`default_nettype wire

// ===== sv/bsc_mul.sv =====
// Shared 32x32 multiplier, low word of the product registered.
// Depends on bsc_pkg.
`default_nettype none
module bsc_mul (
    input  wire logic             i_clk,
    input  wire bsc_pkg::t_mul_req i_req,
    output logic [31:0]           o_prod
);
    import bsc_pkg::*;

    logic [31:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== sv/bsc_wupd.sv =====
// Cipher word update for one byte and the keystream byte it yields.
// Depends on bsc_pkg; the multiply term arrives from bsc_mul.
`default_nettype none
module bsc_wupd (
    input  wire bsc_pkg::t_words i_w,
    input  wire logic [31:0]     i_prod,
    output bsc_pkg::t_words      o_w,
    output logic [7:0]           o_ks
);
    import bsc_pkg::*;

    logic [31:0] t;
    t_words      nw;

    always_comb begin
        t     = i_w[0] ^ rotl32(i_w[3], 7);
        nw[0] = i_w[1] + i_w[4];
        nw[1] = i_w[2] ^ (i_w[5] >> 9);
        nw[2] = i_prod;
        nw[3] = i_w[4] ^ t;
        nw[4] = i_w[5] + i_w[6];
        nw[5] = i_w[6] ^ rotl32(i_w[7], 13);
        nw[6] = i_w[7] + nw[0];
        nw[7] = t ^ (nw[2] >> 11) ^ nw[1];
        o_ks  = '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
            o_ks = o_ks ^ nw[i][7:0];
        end
    end

    assign o_w = nw;

endmodule
`default_nettype wire

// ===== sv/byte_stream_cipher_with_mac.sv =====
// Byte stream cipher with keyed message tag: top level, sequencer and registers.
// Depends on bsc_pkg, bsc_mul, bsc_wupd.
//
// Input stream: one message byte per transfer, tlast marks the last byte.
// Output stream: one result per input byte: tdata = {tag, data_out}, tlast = last.
// tag is zero unless tlast is set.
// APB port: 64-bit registers at 8*i: key words 0..3, then direction.
// Every multiply goes through one shared registered 32x32 multiplier under a
// one-hot sequencer, one multiply per step. A byte's result is loaded into the
// output register in step DONE, after steps M1, UPD, M2, A, M3 and B, and ready
// is high again from then on, so a new byte is taken only once the last is done;
// the last byte of a message adds steps H, F and T for the tag finish.
// s_axis_tready is high only while the sequencer is idle.
// The output register holds a result until taken; while the receiver stalls
// a finished result waits in the sequencer and no new byte is taken.
// Reset (synchronous, active low) clears keys, direction and message state;
// the next byte starts a new message.
`default_nettype none
module byte_stream_cipher_with_mac (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_in[7:0]
    input  wire logic        s_axis_tlast,   // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // data_out[7:0], tag[39:8]
    output logic             m_axis_tlast,   // last_out
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import bsc_pkg::*;

    t_state          r_state, n_state;
    logic [3:0][63:0] r_key;
    logic            r_dir;
    t_words          r_w, n_w;
    logic [31:0]     r_a, n_a, r_b, n_b, r_cnt, n_cnt, r_h, n_h, r_t, n_t;
    logic            r_inmsg, n_inmsg;
    logic [7:0]      r_d, n_d, r_o, n_o, r_p, n_p;
    logic            r_last, n_last;
    logic            r_ov, n_ov;
    logic [39:0]     r_odata, n_odata;
    logic            r_olast, n_olast;

    t_mul_req        mreq;
    logic [31:0]     prod;
    t_words          upd_w;
    logic [7:0]      ks;
    t_words          key_w;
    logic            s_acc, cfg_wr, out_free;
    logic [2:0]      reg_idx;
    logic [7:0]      o_byte;

    bsc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mreq),
        .o_prod (prod)
    );

    bsc_wupd u_wupd (
        .i_w    (r_w),
        .i_prod (prod),
        .o_w    (upd_w),
        .o_ks   (ks)
    );

    assign pready        = 1'b1;
    assign reg_idx       = paddr[5:3];
    assign cfg_wr        = psel && penable && pwrite;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;
    assign o_byte        = r_d ^ ks;

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            key_w[i] = r_key[i >> 1][32*(i & 1) +: 32];
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY0: prdata = r_key[0];
            REG_KEY1: prdata = r_key[1];
            REG_KEY2: prdata = r_key[2];
            REG_KEY3: prdata = r_key[3];
            REG_DIR:  prdata = {63'b0, r_dir};
            default:  prdata = '0;
        endcase
    end

    always_comb begin
        mreq = '{en: 1'b0, a: '0, b: '0};
        case (r_state)
            S_M1:    mreq = '{en: 1'b1, a: r_w[3], b: MUL_STEP};
            S_M2:    mreq = '{en: 1'b1, a: {24'b0, r_p}, b: MUL_GOLD};
            S_M3:    mreq = '{en: 1'b1, a: r_a, b: MUL_STEP};
            S_H:     mreq = '{en: 1'b1, a: r_cnt, b: MUL_COUNT};
            S_F:     mreq = '{en: 1'b1, a: r_h, b: MUL_FINAL};
            default: mreq = '{en: 1'b0, a: '0, b: '0};
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        n_a     = r_a;
        n_b     = r_b;
        n_cnt   = r_cnt;
        n_h     = r_h;
        n_t     = r_t;
        n_inmsg = r_inmsg;
        n_d     = r_d;
        n_o     = r_o;
        n_p     = r_p;
        n_last  = r_last;
        n_ov    = r_ov && !m_axis_tready;
        n_odata = r_odata;
        n_olast = r_olast;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_d     = s_axis_tdata;
                    n_last  = s_axis_tlast;
                    n_state = S_M1;
                    if (!r_inmsg) begin
                        n_w     = key_w;
                        n_a     = TAG_INIT_A ^ key_w[0];
                        n_b     = TAG_INIT_B ^ key_w[1];
                        n_cnt   = '0;
                        n_inmsg = 1'b1;
                    end
                end
            end
            S_M1: n_state = S_UPD;
            S_UPD: begin
                n_w     = upd_w;
                n_o     = o_byte;
                n_p     = r_dir ? o_byte : r_d;
                n_state = S_M2;
            end
            S_M2: n_state = S_A;
            S_A: begin
                n_a     = rotl32(r_a ^ prod, 13) + r_b;
                n_state = S_M3;
            end
            S_M3: n_state = S_B;
            S_B: begin
                n_b     = rotl32(r_b ^ prod, 7) + {24'b0, r_p ^ r_cnt[7:0]};
                n_cnt   = r_cnt + 32'd1;
                n_t     = '0;
                n_state = r_last ? S_H : S_DONE;
            end
            S_H: begin
                n_h     = rotl32(r_a ^ r_b ^ {16'b0, r_key[3][47:32]}, 17);
                n_state = S_F;
            end
            S_F: begin
                n_t     = prod ^ r_b;
                n_state = S_T;
            end
            S_T: begin
                n_t     = r_t ^ prod;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_odata = {r_t, r_o};
                    n_olast = r_last;
                    n_inmsg = !r_last;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
            r_dir   <= 1'b0;
            r_a     <= '0;
            r_b     <= '0;
            r_cnt   <= '0;
            r_inmsg <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a     <= n_a;
            r_b     <= n_b;
            r_cnt   <= n_cnt;
            r_inmsg <= n_inmsg;
            r_ov    <= n_ov;
            if (cfg_wr) begin
                case (reg_idx)
                    REG_KEY0: r_key[0] <= pwdata;
                    REG_KEY1: r_key[1] <= pwdata;
                    REG_KEY2: r_key[2] <= pwdata;
                    REG_KEY3: r_key[3] <= pwdata;
                    REG_DIR:  r_dir    <= pwdata[0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_h     <= n_h;
        r_t     <= n_t;
        r_d     <= n_d;
        r_o     <= n_o;
        r_p     <= n_p;
        r_last  <= n_last;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input taken while a byte is in flight");

    a_count_clear_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !r_inmsg) |=> (r_cnt == 32'd0) && r_inmsg)
        else $error("message start did not reset byte count");

    a_tag_zero_mid_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[39:8] == 32'd0))
        else $error("nonzero tag on a byte that does not end the message");
`endif

endmodule
`default_nettype wire

// ===== bench/cipher_tag_checker.sv =====
// Checker for byte_stream_cipher_with_mac: tracks APB register writes and input
// transfers, predicts each output transfer and compares it field by field.
// Depends on bsc_pkg for the register indexes.
module cipher_tag_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_in[7:0]
    input  wire logic        s_axis_tlast,   // end_of_message
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,   // data_out[7:0], tag[39:8]
    input  wire logic        m_axis_tlast,   // last_out
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    output int               o_mismatches,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam logic [31:0] STEP_MULT  = 32'hBF58476D;
    localparam logic [31:0] GOLDEN     = 32'h9E3779B9;
    localparam logic [31:0] TAG_SEED_A = 32'h6A09E667;
    localparam logic [31:0] TAG_SEED_B = 32'hBB67AE85;
    localparam logic [31:0] FINAL_MULT = 32'h94D049BB;
    localparam logic [31:0] COUNT_MULT = 32'h6C62272E;

    typedef struct packed {
        logic [7:0]  text;
        logic [31:0] tag;
        logic        last;
    } cipher_out_t;

    logic [63:0] key_reg [4];
    logic        decrypt;
    logic [31:0] words [8];
    logic [31:0] mac_a;
    logic [31:0] mac_b;
    logic [31:0] msg_bytes;
    logic        msg_open;

    cipher_out_t expected_q [$];
    cipher_out_t predicted;
    cipher_out_t want;
    int          results_seen;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} << n;
        return twice[63:32];
    endfunction

    function automatic logic [31:0] key_word(input int i);
        logic [63:0] r;
        r = key_reg[i / 2];
        return (i % 2) ? r[63:32] : r[31:0];
    endfunction

    task automatic encipher_byte(input logic [7:0] din, input logic eom,
                                 output cipher_out_t res);
        logic [31:0] t, ks, p, a, b, h;
        if (!msg_open) begin
            for (int i = 0; i < 8; i++) words[i] = key_word(i);
            mac_a     = TAG_SEED_A ^ key_word(0);
            mac_b     = TAG_SEED_B ^ key_word(1);
            msg_bytes = '0;
            msg_open  = 1'b1;
        end
        // words 6 and 7 see words already renewed in this step
        t        = words[0] ^ rol(words[3], 7);
        words[0] = words[1] + words[4];
        words[1] = words[2] ^ (words[5] >> 9);
        words[2] = words[3] * STEP_MULT;
        words[3] = words[4] ^ t;
        words[4] = words[5] + words[6];
        words[5] = words[6] ^ rol(words[7], 13);
        words[6] = words[7] + words[0];
        words[7] = t ^ (words[2] >> 11) ^ words[1];
        ks = '0;
        foreach (words[i]) ks ^= words[i];
        res.text = din ^ ks[7:0];
        p = decrypt ? {24'b0, res.text} : {24'b0, din};
        a = rol(mac_a ^ (p * GOLDEN), 13) + mac_b;
        b = rol(mac_b ^ (a * STEP_MULT), 7) + (p ^ {24'b0, msg_bytes[7:0]});
        mac_a     = a;
        mac_b     = b;
        msg_bytes = msg_bytes + 32'd1;
        res.tag  = '0;
        res.last = eom;
        if (eom) begin
            h = rol(a ^ b ^ {16'b0, key_reg[3][47:32]}, 17) * FINAL_MULT;
            res.tag  = h ^ b ^ (msg_bytes * COUNT_MULT);
            msg_open = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (o_mismatches < 30)
            $display("result %0d: %s is %h, expected %h", results_seen, what, got, exp_val);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (key_reg[i]) key_reg[i] = '0;
            foreach (words[i]) words[i] = '0;
            decrypt   = 1'b0;
            mac_a     = '0;
            mac_b     = '0;
            msg_bytes = '0;
            msg_open  = 1'b0;
            results_seen = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[paddr[4:3]] = pwdata;
                    REG_DIR: decrypt = pwdata[0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unrequested transfer, data", {24'b0, m_axis_tdata[7:0]},
                                    '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.text)
                        report_mismatch("data_out", {24'b0, m_axis_tdata[7:0]},
                                        {24'b0, want.text});
                    if (m_axis_tdata[39:8] !== want.tag)
                        report_mismatch("tag", m_axis_tdata[39:8], want.tag);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_out", {31'b0, m_axis_tlast}, {31'b0, want.last});
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                encipher_byte(s_axis_tdata, s_axis_tlast, predicted);
                expected_q.push_back(predicted);
            end
        end
        o_outstanding <= expected_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for byte_stream_cipher_with_mac: clock, reset, APB register
// writes, bursty byte stimulus and a stalling receiver; verdict from the checker.
// Depends on bsc_pkg, the block's RTL and cipher_tag_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsc_pkg::*;

    localparam int          ITEMS        = 700;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          SETTLE_WAIT  = 32;
    localparam logic [2:0]  REG_NONE     = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_HOLD, RX_MOSTLY} rx_mode_t;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;      // data_in[7:0]
    logic        s_axis_tlast  = 1'b0;    // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // data_out[7:0], tag[39:8]
    logic        m_axis_tlast;            // last_out
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [5:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int quiet_cycles  = 0;
    int burst_left    = 0;
    int bytes_sent    = 0;
    int messages_sent = 0;
    int settings      = 1;
    int msg_left      = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    logic [2:0] key_regs [4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

    byte_stream_cipher_with_mac u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    cipher_tag_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: stretches of always ready, coin flips, full stalls, mostly ready
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 24) : $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  m_axis_tready <= 1'b1;
            RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
            RX_HOLD:  m_axis_tready <= 1'b0;
            default:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, outstanding);
        $display("byte_stream_cipher_with_mac test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic eom);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (eom) messages_sent++;
    endtask

    // hold the input until every predicted result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 1;
        if (roll < 7)  return $urandom_range(1, 6);
        return $urandom_range(7, 24);
    endfunction

    task automatic retune();
        for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 1)) reg_write(key_regs[i], pick_key());
        if ($urandom_range(0, 1)) reg_write(REG_DIR, {$urandom, $urandom});
        settings++;
    endtask

    initial begin
        int phase_len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key, encrypt, single-byte message
        send_byte(8'h00, 1'b1);
        drain();

        for (int i = 0; i < 4; i++) reg_write(key_regs[i], '1);
        settings++;
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        drain();

        for (int i = 0; i < 4; i++) reg_write(key_regs[i], {$urandom, $urandom});
        reg_write(REG_DIR, 64'd1);
        settings++;
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7E, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain();

        // key, direction and a write past the register list, mid-message
        reg_write(REG_KEY3, {$urandom, $urandom});
        reg_write(REG_KEY0, '0);
        reg_write(REG_DIR, 64'd0);
        reg_write(REG_NONE, '1);
        settings++;
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);

        // random part: first message is long enough to wrap the byte index
        msg_left = 300;
        while (bytes_sent < ITEMS || msg_left != 0) begin
            drain();
            retune();
            phase_len = $urandom_range(10, 60);
            for (int n = 0; n < phase_len; n++) begin
                if (msg_left == 0 && bytes_sent >= ITEMS) break;
                if (msg_left == 0) msg_left = pick_length();
                msg_left--;
                send_byte(8'($urandom_range(0, 255)), msg_left == 0);
            end
        end

        drain();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        $display("covered %0d bytes in %0d messages under %0d key/direction settings,",
                 bytes_sent, messages_sent, settings);
        $display("including single-byte, long and register-update-spanning messages");
        if (mismatches == 0)
            $display("byte_stream_cipher_with_mac test passed");
        else
            $display("byte_stream_cipher_with_mac test failed");
        $finish;
    end

endmodule
